### hw/rtl/gpe_pkg.sv
// Shared types, codes and pin mask helpers for the GPIO port with edge interrupts.
// Used by every module of the block; depends on nothing.
package gpe_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] REG_MODE     = 4'd0;
    localparam logic [3:0] REG_OTYPE    = 4'd1;
    localparam logic [3:0] REG_SPEED    = 4'd2;
    localparam logic [3:0] REG_PULL     = 4'd3;
    localparam logic [3:0] REG_INPUT    = 4'd4;
    localparam logic [3:0] REG_OUTPUT   = 4'd5;
    localparam logic [3:0] REG_SETRESET = 4'd6;
    localparam logic [3:0] REG_AFL      = 4'd7;
    localparam logic [3:0] REG_AFH      = 4'd8;
    localparam logic [3:0] REG_RISE     = 4'd9;
    localparam logic [3:0] REG_FALL     = 4'd10;
    localparam logic [3:0] REG_MASK     = 4'd11;
    localparam logic [3:0] REG_PENDING  = 4'd12;

    localparam int MAX_PINS = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] out_levels;
        logic [15:0] pending_lines;
        logic        irq;
    } t_result;

    function automatic logic [15:0] mask_one(input int pins);
        logic [15:0] m;
        m = '0;
        for (int p = 0; p < MAX_PINS; p++) begin
            if (p < pins) begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] mask_two(input int pins);
        logic [31:0] m;
        m = '0;
        for (int p = 0; p < MAX_PINS; p++) begin
            if (p < pins) begin
                m[2*p +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] mask_four(input int first, input int pins);
        logic [31:0] m;
        m = '0;
        for (int p = 0; p < 8; p++) begin
            if ((first + p) < pins) begin
                m[4*p +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

### hw/rtl/gpe_in_reg.sv
// Input register of the GPIO port: takes one item per cycle unless stalled; holds it for the register file.
// Depends on gpe_pkg for the item type.
module gpe_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  gpe_pkg::t_item  i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output gpe_pkg::t_item  o_item
);

    logic           r_valid;
    gpe_pkg::t_item r_item;
    logic           w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hw/rtl/gpe_regfile.sv
// Register file and edge detector of the GPIO port: applies one item and forms its result.
// Depends on gpe_pkg for codes, types and pin masks.
module gpe_regfile #(
    parameter int PIN_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  gpe_pkg::t_item   i_item,
    output gpe_pkg::t_result o_result
);

    localparam logic [15:0] M1  = gpe_pkg::mask_one(PIN_COUNT);
    localparam logic [31:0] M2  = gpe_pkg::mask_two(PIN_COUNT);
    localparam logic [31:0] M4L = gpe_pkg::mask_four(0, PIN_COUNT);
    localparam logic [31:0] M4H = gpe_pkg::mask_four(8, PIN_COUNT);

    logic [31:0] r_mode,  n_mode;
    logic [15:0] r_otype, n_otype;
    logic [31:0] r_speed, n_speed;
    logic [31:0] r_pull,  n_pull;
    logic [31:0] r_afl,   n_afl;
    logic [31:0] r_afh,   n_afh;
    logic [15:0] r_out,   n_out;
    logic [15:0] r_in,    n_in;
    logic [15:0] r_prev,  n_prev;
    logic [15:0] r_rise,  n_rise;
    logic [15:0] r_fall,  n_fall;
    logic [15:0] r_mask,  n_mask;
    logic [15:0] r_pend,  n_pend;
    logic [31:0] w_rd;
    logic [15:0] w_pins;
    logic [31:0] w_d;

    assign w_pins = i_item.pin_levels & M1;
    assign w_d    = i_item.write_data;

    always_comb begin
        n_mode  = r_mode;
        n_otype = r_otype;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_afl   = r_afl;
        n_afh   = r_afh;
        n_out   = r_out;
        n_in    = r_in;
        n_prev  = r_prev;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_mask  = r_mask;
        n_pend  = r_pend;
        w_rd    = '0;
        case (i_item.op)
            gpe_pkg::OP_READ: begin
                case (i_item.reg_select)
                    gpe_pkg::REG_MODE:    w_rd = r_mode;
                    gpe_pkg::REG_OTYPE:   w_rd = {16'b0, r_otype};
                    gpe_pkg::REG_SPEED:   w_rd = r_speed;
                    gpe_pkg::REG_PULL:    w_rd = r_pull;
                    gpe_pkg::REG_INPUT:   w_rd = {16'b0, r_in};
                    gpe_pkg::REG_OUTPUT:  w_rd = {16'b0, r_out};
                    gpe_pkg::REG_AFL:     w_rd = r_afl;
                    gpe_pkg::REG_AFH:     w_rd = r_afh;
                    gpe_pkg::REG_RISE:    w_rd = {16'b0, r_rise};
                    gpe_pkg::REG_FALL:    w_rd = {16'b0, r_fall};
                    gpe_pkg::REG_MASK:    w_rd = {16'b0, r_mask};
                    gpe_pkg::REG_PENDING: w_rd = {16'b0, r_pend};
                    default:              w_rd = '0;
                endcase
            end
            gpe_pkg::OP_WRITE: begin
                case (i_item.reg_select)
                    gpe_pkg::REG_MODE:     n_mode  = w_d & M2;
                    gpe_pkg::REG_OTYPE:    n_otype = w_d[15:0] & M1;
                    gpe_pkg::REG_SPEED:    n_speed = w_d & M2;
                    gpe_pkg::REG_PULL:     n_pull  = w_d & M2;
                    gpe_pkg::REG_OUTPUT:   n_out   = w_d[15:0] & M1;
                    gpe_pkg::REG_SETRESET: n_out   = ((r_out & ~w_d[31:16]) | w_d[15:0]) & M1;
                    gpe_pkg::REG_AFL:      n_afl   = w_d & M4L;
                    gpe_pkg::REG_AFH:      n_afh   = w_d & M4H;
                    gpe_pkg::REG_RISE:     n_rise  = w_d[15:0] & M1;
                    gpe_pkg::REG_FALL:     n_fall  = w_d[15:0] & M1;
                    gpe_pkg::REG_MASK:     n_mask  = w_d[15:0] & M1;
                    gpe_pkg::REG_PENDING:  n_pend  = r_pend & ~w_d[15:0] & M1;
                    default:               n_pend  = r_pend;
                endcase
            end
            gpe_pkg::OP_TICK: begin
                n_pend = r_pend | (~r_prev & w_pins & r_rise) | (r_prev & ~w_pins & r_fall);
                n_in   = w_pins;
                n_prev = w_pins;
            end
            default: begin
                w_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_otype <= '0;
            r_speed <= '0;
            r_pull  <= '0;
            r_afl   <= '0;
            r_afh   <= '0;
            r_out   <= '0;
            r_in    <= '0;
            r_prev  <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_mask  <= '0;
            r_pend  <= '0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_otype <= n_otype;
            r_speed <= n_speed;
            r_pull  <= n_pull;
            r_afl   <= n_afl;
            r_afh   <= n_afh;
            r_out   <= n_out;
            r_in    <= n_in;
            r_prev  <= n_prev;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_mask  <= n_mask;
            r_pend  <= n_pend;
        end
    end

    assign o_result.read_data     = w_rd;
    assign o_result.out_levels    = n_out;
    assign o_result.pending_lines = n_pend;
    assign o_result.irq           = |(n_pend & n_mask);

endmodule

### hw/rtl/gpe_out_reg.sv
// Result register of the GPIO port: holds one result item until the receiver takes it.
// Depends on gpe_pkg for the result type.
module gpe_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gpe_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output gpe_pkg::t_result o_result
);

    logic             r_valid;
    gpe_pkg::t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/gpio_port_with_edge_interrupts_core.sv
// Top level of the 16-pin GPIO port with edge-triggered interrupt lines.
// Depends on gpe_pkg, gpe_in_reg, gpe_regfile and gpe_out_reg.
//
// Usage:
// The input channel (i_in_valid / o_in_stall) carries one item per cycle: a register
// read, a register write or a pin sample tick, chosen by i_op. An item is taken at a
// rising edge where i_in_valid is high and o_in_stall is low.
// Every item gives exactly one result item on the output channel
// (o_out_valid / i_out_stall): read data, output latch, pending bits and irq, all as
// they stand after the item is applied.
// Each item passes the input register, the register file logic and the result register,
// which takes its result item as the item leaves the input register.
// Throughput: one item per cycle while the output is not stalled.
// When the receiver stalls, the result register holds its item and the input register
// keeps taking one more; o_in_stall rises once both registers are full and the output
// is still stalled.
// Reset (i_rst_n low, synchronous) clears every register of the port to zero, leaves
// all lines masked and empties both stages. No clearing pass is needed.
module gpio_port_with_edge_interrupts_core #(
    parameter int PIN_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_reg_select,
    input  logic [31:0] i_write_data,
    input  logic [15:0] i_pin_levels,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [15:0] o_out_levels,
    output logic [15:0] o_pending_lines,
    output logic        o_irq
);

    gpe_pkg::t_item   w_in_item;
    gpe_pkg::t_item   w_stage_item;
    gpe_pkg::t_result w_result;
    gpe_pkg::t_result w_out_result;
    logic             w_stage_valid;
    logic             w_out_ready;
    logic             w_advance;

    assign w_in_item.op         = i_op;
    assign w_in_item.reg_select = i_reg_select;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.pin_levels = i_pin_levels;

    assign w_advance = w_stage_valid && w_out_ready;

    gpe_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    gpe_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_item   (w_stage_item),
        .o_result (w_result)
    );

    gpe_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_stage_valid),
        .i_result (w_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_read_data     = w_out_result.read_data;
    assign o_out_levels    = w_out_result.out_levels;
    assign o_pending_lines = w_out_result.pending_lines;
    assign o_irq           = w_out_result.irq;

`ifndef SYNTH
    a_irq_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq) |-> (o_pending_lines != 16'd0))
        else $error("irq raised with no pending line");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_stage_valid && o_out_valid && i_out_stall))
        else $error("input stalled while a stage is free");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("stages not empty after reset");
`endif

endmodule

### bench/tb_gpio_port_with_edge_interrupts_core.sv
// Self-checking bench for the GPIO port with edge interrupts: reads, writes and pin ticks
// go in through a random-idling driver; a monitor checks every result against a predictor.
// Depends on gpe_pkg and gpio_port_with_edge_interrupts_core.
`timescale 1ns / 1ps

module tb_gpio_port_with_edge_interrupts_core;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 700;
    localparam int PHASE_ONE_AT = 240;
    localparam int PHASE_TWO_AT = 480;
    localparam int HOLD_AT = 560;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        gpe_pkg::t_item item;
        bit             drain;
    } t_port_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = gpe_pkg::OP_READ;
    logic [3:0]  i_reg_select = gpe_pkg::REG_MODE;
    logic [31:0] i_write_data = '0;
    logic [15:0] i_pin_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_read_data;
    logic [15:0] o_out_levels;
    logic [15:0] o_pending_lines;
    logic        o_irq;

    t_port_access     access_q[$];
    gpe_pkg::t_result port_results_q[$];

    logic [31:0] mode_r = '0;
    logic [15:0] otype_r = '0;
    logic [31:0] speed_r = '0;
    logic [31:0] pull_r = '0;
    logic [31:0] afl_r = '0;
    logic [31:0] afh_r = '0;
    logic [15:0] out_latch_r = '0;
    logic [15:0] in_latch_r = '0;
    logic [15:0] prev_pins_r = '0;
    logic [15:0] rise_r = '0;
    logic [15:0] fall_r = '0;
    logic [15:0] line_mask_r = '0;
    logic [15:0] pending_r = '0;

    int  taken_count = 0;
    int  total_items = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  taken_last = 1'b0;

    gpio_port_with_edge_interrupts_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_reg_select    (i_reg_select),
        .i_write_data    (i_write_data),
        .i_pin_levels    (i_pin_levels),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_data     (o_read_data),
        .o_out_levels    (o_out_levels),
        .o_pending_lines (o_pending_lines),
        .o_irq           (o_irq)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic gpe_pkg::t_result apply_port_access(gpe_pkg::t_item it);
        gpe_pkg::t_result r;
        r = '0;
        case (it.op)
            gpe_pkg::OP_READ: begin
                case (it.reg_select)
                    gpe_pkg::REG_MODE:    r.read_data = mode_r;
                    gpe_pkg::REG_OTYPE:   r.read_data = {16'h0, otype_r};
                    gpe_pkg::REG_SPEED:   r.read_data = speed_r;
                    gpe_pkg::REG_PULL:    r.read_data = pull_r;
                    gpe_pkg::REG_INPUT:   r.read_data = {16'h0, in_latch_r};
                    gpe_pkg::REG_OUTPUT:  r.read_data = {16'h0, out_latch_r};
                    gpe_pkg::REG_AFL:     r.read_data = afl_r;
                    gpe_pkg::REG_AFH:     r.read_data = afh_r;
                    gpe_pkg::REG_RISE:    r.read_data = {16'h0, rise_r};
                    gpe_pkg::REG_FALL:    r.read_data = {16'h0, fall_r};
                    gpe_pkg::REG_MASK:    r.read_data = {16'h0, line_mask_r};
                    gpe_pkg::REG_PENDING: r.read_data = {16'h0, pending_r};
                    default:              r.read_data = '0;
                endcase
            end
            gpe_pkg::OP_WRITE: begin
                case (it.reg_select)
                    gpe_pkg::REG_MODE:     mode_r = it.write_data;
                    gpe_pkg::REG_OTYPE:    otype_r = it.write_data[15:0];
                    gpe_pkg::REG_SPEED:    speed_r = it.write_data;
                    gpe_pkg::REG_PULL:     pull_r = it.write_data;
                    gpe_pkg::REG_OUTPUT:   out_latch_r = it.write_data[15:0];
                    gpe_pkg::REG_SETRESET: begin
                        out_latch_r = (out_latch_r & ~it.write_data[31:16])
                                      | it.write_data[15:0];
                    end
                    gpe_pkg::REG_AFL:      afl_r = it.write_data;
                    gpe_pkg::REG_AFH:      afh_r = it.write_data;
                    gpe_pkg::REG_RISE:     rise_r = it.write_data[15:0];
                    gpe_pkg::REG_FALL:     fall_r = it.write_data[15:0];
                    gpe_pkg::REG_MASK:     line_mask_r = it.write_data[15:0];
                    gpe_pkg::REG_PENDING:  pending_r = pending_r & ~it.write_data[15:0];
                    default: ;
                endcase
            end
            gpe_pkg::OP_TICK: begin
                pending_r = pending_r | (~prev_pins_r & it.pin_levels & rise_r)
                            | (prev_pins_r & ~it.pin_levels & fall_r);
                in_latch_r = it.pin_levels;
                prev_pins_r = it.pin_levels;
            end
            default: ;
        endcase
        r.out_levels = out_latch_r;
        r.pending_lines = pending_r;
        r.irq = |(pending_r & line_mask_r);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor_results
        gpe_pkg::t_result exp_res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (port_results_q.size() == 0) begin
                    $display("%0t unexpected item: read_data %h out_levels %h pending %h irq %b",
                             $time, o_read_data, o_out_levels, o_pending_lines, o_irq);
                    mismatches++;
                end else begin
                    exp_res = port_results_q.pop_front();
                    check_field("read_data", exp_res.read_data, o_read_data);
                    check_field("out_levels", 32'(exp_res.out_levels), 32'(o_out_levels));
                    check_field("pending_lines", 32'(exp_res.pending_lines),
                                32'(o_pending_lines));
                    check_field("irq", 32'(exp_res.irq), 32'(o_irq));
                end
            end
            taken_last = i_in_valid && !o_in_stall;
            if (taken_last) begin
                port_results_q.push_back(apply_port_access(
                    '{op: i_op, reg_select: i_reg_select,
                      write_data: i_write_data, pin_levels: i_pin_levels}));
                taken_count++;
            end
        end
    end

    always @(negedge i_clk) begin : drive_items
        bit           next_valid;
        int           idle_pct;
        t_port_access pend;
        idle_pct = (taken_count < PHASE_ONE_AT) ? 34 : (taken_count < PHASE_TWO_AT) ? 52 : 0;
        next_valid = i_in_valid && !taken_last;
        if (i_rst_n && !next_valid && access_q.size() != 0) begin
            if (access_q[0].drain) begin
                if (port_results_q.size() == 0) begin
                    void'(access_q.pop_front());
                end
            end else if ($urandom_range(99) >= idle_pct) begin
                pend = access_q.pop_front();
                i_op <= pend.item.op;
                i_reg_select <= pend.item.reg_select;
                i_write_data <= pend.item.write_data;
                i_pin_levels <= pend.item.pin_levels;
                next_valid = 1'b1;
            end
        end
        i_in_valid <= next_valid;
    end

    always @(negedge i_clk) begin : drive_stall
        int idle_pct;
        idle_pct = (taken_count < PHASE_ONE_AT) ? 52 : (taken_count < PHASE_TWO_AT) ? 34 : 0;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && taken_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_access(logic [1:0] op, logic [3:0] sel, logic [31:0] data,
                                logic [15:0] pins);
        access_q.push_back('{item: '{op: op, reg_select: sel, write_data: data,
                                     pin_levels: pins}, drain: 1'b0});
        total_items++;
    endtask

    initial begin : stimulus
        int          n;
        int          r;
        logic [1:0]  op;
        logic [3:0]  sel;
        logic [31:0] data;
        logic [15:0] pins;
        logic [15:0] last_pins;

        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_RISE, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_FALL, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_MASK, 32'hFFFF_FFFF, 16'h0);
        // all pins high on the first tick count as rising
        queue_access(gpe_pkg::OP_TICK, gpe_pkg::REG_MODE, 32'h0, 16'hFFFF);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_PENDING, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_PENDING, 32'h0000_00FF, 16'h0);
        queue_access(gpe_pkg::OP_TICK, gpe_pkg::REG_MODE, 32'hFFFF_FFFF, 16'h0000);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_PENDING, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_INPUT, 32'hFFFF_FFFF, 16'hFFFF);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_INPUT, 32'h0, 16'h0);
        // set wins over clear on the same pin
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_SETRESET, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_SETRESET, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_SETRESET, 32'hFFFF_0000, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_OUTPUT, 32'hA5A5_A5A5, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_MODE, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_MODE, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_OTYPE, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_OTYPE, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_SPEED, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_PULL, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_AFL, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_AFH, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_AFH, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_PENDING + 4'd3, 32'hFFFF_FFFF, 16'h0);
        queue_access(gpe_pkg::OP_READ, gpe_pkg::REG_PENDING + 4'd1, 32'h0, 16'h0);
        queue_access(OP_NONE, gpe_pkg::REG_MODE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_access(gpe_pkg::OP_WRITE, gpe_pkg::REG_MASK, 32'h0, 16'h0);
        queue_access(gpe_pkg::OP_TICK, gpe_pkg::REG_MODE, 32'h0, 16'h5555);
        last_pins = 16'h5555;

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                access_q.push_back('{item: '0, drain: 1'b1});
            end
            r = $urandom_range(99);
            op = (r < 30) ? gpe_pkg::OP_READ : (r < 60) ? gpe_pkg::OP_WRITE :
                 (r < 95) ? gpe_pkg::OP_TICK : OP_NONE;
            if ($urandom_range(99) < 6) begin
                sel = gpe_pkg::REG_PENDING + 4'($urandom_range(1, 3));
            end else begin
                sel = 4'($urandom_range(gpe_pkg::REG_MODE, gpe_pkg::REG_PENDING));
            end
            case ($urandom_range(9))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom();
            endcase
            case ($urandom_range(9))
                0:          pins = '0;
                1:          pins = '1;
                2, 3, 4, 5: pins = last_pins ^ (16'h1 << $urandom_range(15));
                default:    pins = 16'($urandom());
            endcase
            if (op == gpe_pkg::OP_TICK) begin
                last_pins = pins;
            end
            queue_access(op, sel, data, pins);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_count < total_items || port_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
